@@ rtl/rsw_pkg.sv @@
package rsw_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int RADIUS_W        = 32;
  localparam int INTEN_W         = 24;
  localparam logic [INTEN_W-1:0] INTEN_RESET = 24'd65536;

  // square root: 64-bit radicand, one result bit per cell
  localparam int SQ_W        = 64;
  localparam int SQRT_STEPS  = 32;
  localparam int ROOT_W      = 32;
  localparam int SQ_REM_W    = 34;

  // falloff divide: one quotient bit per cell
  localparam int DIV_STEPS   = 32;
  localparam int QUOT_W      = 32;

  // smoothstep weight
  localparam int FRAC_BITS   = 31;
  localparam int SMAG_W      = 56;
  localparam logic [33:0] SMOOTH_THREE = 34'h1_8000_0000;
  localparam int DISP_SHIFT  = 47;
  localparam int LANE_LAT    = 5;

  typedef enum logic [2:0] {
    REG_START_X   = 3'd0,
    REG_START_Y   = 3'd1,
    REG_TARGET_X  = 3'd2,
    REG_TARGET_Y  = 3'd3,
    REG_RADIUS    = 3'd4,
    REG_INTENSITY = 3'd5
  } reg_index_t;

endpackage

@@ rtl/rsw_if.sv @@
interface rsw_vertex_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] vertex_x;
  logic [W-1:0] vertex_y;
  modport source (output valid, vertex_x, vertex_y, input ready);
  modport sink (input valid, vertex_x, vertex_y, output ready);
endinterface

interface rsw_result_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] moved_x;
  logic [W-1:0] moved_y;
  logic         inside_radius;
  modport source (output valid, moved_x, moved_y, inside_radius, input ready);
  modport sink (input valid, moved_x, moved_y, inside_radius, output ready);
endinterface

@@ rtl/rsw_sqrt_cell.sv @@
module rsw_sqrt_cell import rsw_pkg::*; #(
  parameter int TAG_W = 65
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [SQ_W-1:0]     in_n,
  input  logic [SQ_REM_W-1:0] in_rem,
  input  logic [ROOT_W-1:0]   in_root,
  input  logic [TAG_W-1:0]    in_tag,
  output logic                out_valid,
  output logic [SQ_W-1:0]     out_n,
  output logic [SQ_REM_W-1:0] out_rem,
  output logic [ROOT_W-1:0]   out_root,
  output logic [TAG_W-1:0]    out_tag
);

  logic [SQ_REM_W+1:0] rem_sh;
  logic [SQ_REM_W+1:0] trial;
  logic [SQ_REM_W+1:0] diff;
  logic                ge;

  // bring down the next two radicand bits, try root*4+1
  always_comb begin
    rem_sh = {in_rem, in_n[SQ_W-1 -: 2]};
    trial  = {2'b00, in_root, 2'b01};
    ge     = rem_sh >= trial;
    diff   = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
      out_n     <= {in_n[SQ_W-3:0], 2'b00};
      out_rem   <= ge ? diff[SQ_REM_W-1:0] : rem_sh[SQ_REM_W-1:0];
      out_root  <= {in_root[ROOT_W-2:0], ge};
      out_tag   <= in_tag;
    end
  end

endmodule

@@ rtl/rsw_div_cell.sv @@
module rsw_div_cell import rsw_pkg::*; #(
  parameter int TAG_W = 65
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [RADIUS_W-1:0] divisor,
  input  logic                in_valid,
  input  logic [RADIUS_W-1:0] in_rem,
  input  logic [QUOT_W-1:0]   in_num,
  input  logic [QUOT_W-1:0]   in_q,
  input  logic [TAG_W-1:0]    in_tag,
  output logic                out_valid,
  output logic [RADIUS_W-1:0] out_rem,
  output logic [QUOT_W-1:0]   out_num,
  output logic [QUOT_W-1:0]   out_q,
  output logic [TAG_W-1:0]    out_tag
);

  logic [RADIUS_W:0] rem_sh;
  logic [RADIUS_W:0] diff;
  logic              ge;

  always_comb begin
    rem_sh = {in_rem, in_num[QUOT_W-1]};
    ge     = rem_sh >= {1'b0, divisor};
    diff   = rem_sh - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
      out_rem   <= ge ? diff[RADIUS_W-1:0] : rem_sh[RADIUS_W-1:0];
      out_num   <= {in_num[QUOT_W-2:0], 1'b0};
      out_q     <= {in_q[QUOT_W-2:0], ge};
      out_tag   <= in_tag;
    end
  end

endmodule

@@ rtl/rsw_move_lane.sv @@
module rsw_move_lane import rsw_pkg::*; #(
  parameter int W = 32
) (
  input  logic              clk,
  input  logic              en,
  input  logic [W-1:0]      start,
  input  logic [W-1:0]      target,
  input  logic [SMAG_W-1:0] s_mag,
  input  logic              s_neg,
  input  logic [W-1:0]      v,
  input  logic              hit,
  output logic [W-1:0]      moved
);

  localparam int DW  = W + 1;
  localparam int DLO = (DW + 1) / 2;
  localparam int DHI = DW - DLO;
  localparam int SLO = SMAG_W / 2;
  localparam int SHI = SMAG_W - SLO;
  localparam int PW  = DW + SMAG_W;
  localparam int QW  = PW + 1 - DISP_SHIFT;
  localparam int SW  = QW + 2;
  localparam logic [PW:0] RND = (PW+1)'((65'd1 << DISP_SHIFT) - 65'd1);

  logic signed [DW-1:0] delta;
  logic [DW-1:0]        dmag;

  logic [DLO+SLO-1:0] pp0;
  logic [DLO+SHI-1:0] pp1;
  logic [DHI+SLO-1:0] pp2;
  logic [DHI+SHI-1:0] pp3;
  logic [PW-1:0]      a1, b1, prod;
  logic [QW-1:0]      q3;
  logic [PW:0]        adj;
  logic [SW-1:0]      disp, sum;
  logic               neg0, neg1, neg2, neg3;
  logic [W-1:0]       v0, v1, v2, v3;
  logic               in0, in1, in2, in3;
  logic               ovf;

  // the user must keep the drag vector fixed while items flow; the block does not enforce it
  always_comb begin
    delta = $signed({target[W-1], target}) - $signed({start[W-1], start});
    dmag  = delta[DW-1] ? (~delta + 1'b1) : delta;
  end

  always_comb begin
    adj  = {1'b0, prod} + (neg2 ? RND : '0);
    disp = neg3 ? (~{2'b00, q3} + 1'b1) : {2'b00, q3};
    sum  = {{(SW-W){v3[W-1]}}, v3} + disp;
    ovf  = (sum[SW-1:W-1] != '0) && (sum[SW-1:W-1] != '1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // split product, each partial within 32x32
      pp0  <= dmag[DLO-1:0] * s_mag[SLO-1:0];
      pp1  <= dmag[DLO-1:0] * s_mag[SMAG_W-1:SLO];
      pp2  <= dmag[DW-1:DLO] * s_mag[SLO-1:0];
      pp3  <= dmag[DW-1:DLO] * s_mag[SMAG_W-1:SLO];
      neg0 <= delta[DW-1] ^ s_neg;
      v0   <= v;
      in0  <= hit;

      a1   <= PW'(pp0) + (PW'(pp1) << SLO);
      b1   <= PW'(pp2) + (PW'(pp3) << SLO);
      neg1 <= neg0;
      v1   <= v0;
      in1  <= in0;

      prod <= a1 + (b1 << DLO);
      neg2 <= neg1;
      v2   <= v1;
      in2  <= in1;

      // floor toward minus infinity for a negative displacement
      q3   <= adj[PW:DISP_SHIFT];
      neg3 <= neg2;
      v3   <= v2;
      in3  <= in2;

      if (!in3) begin
        moved <= v3;
      end else if (ovf) begin
        moved <= sum[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        moved <= sum[W-1:0];
      end
    end
  end

endmodule

@@ rtl/radial_smoothstep_warp_unit.sv @@
// channel   dir  payload                               handshake
// vertices  in   vertex_x, vertex_y                    valid/ready
// results   out  moved_x, moved_y, inside_radius       valid/ready
// apb       cfg  six registers, one per word           psel/penable, pready high
//
// one item per cycle while the skid entry is empty; an item passes the front end,
// the 32-cell square root and divide chains, the weight, lane and output registers
// rst clears all valid flags and loads the register reset values
// a full output register plus one skid entry stall the whole cell chain together
module radial_smoothstep_warp_unit import rsw_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int PDW = (COORD_WIDTH > 32) ? 64 : 32,
  localparam int PAW = (COORD_WIDTH > 32) ? 6 : 5
) (
  input  logic                clk,
  input  logic                rst,
  rsw_vertex_if.sink          vertices,
  rsw_result_if.source        results,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PAW-1:0]      paddr,
  input  logic [PDW-1:0]      pwdata,
  output logic [PDW-1:0]      prdata,
  output logic                pready
);

  localparam int W     = COORD_WIDTH;
  localparam int ASH   = (COORD_WIDTH > 32) ? 3 : 2;
  localparam int MW    = W + 33;
  localparam int TAG_W = 2 * W + 1;

  logic [W-1:0]        start_x, start_y, target_x, target_y;
  logic [RADIUS_W-1:0] radius;
  logic [INTEN_W-1:0]  intensity;
  logic [2:0]          reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PAW-1:ASH];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x   <= '0;
      start_y   <= '0;
      target_x  <= '0;
      target_y  <= '0;
      radius    <= '0;
      intensity <= INTEN_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_START_X:   start_x   <= pwdata[W-1:0];
        REG_START_Y:   start_y   <= pwdata[W-1:0];
        REG_TARGET_X:  target_x  <= pwdata[W-1:0];
        REG_TARGET_Y:  target_y  <= pwdata[W-1:0];
        REG_RADIUS:    radius    <= pwdata[RADIUS_W-1:0];
        REG_INTENSITY: intensity <= pwdata[INTEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_START_X:   prdata = PDW'(start_x);
      REG_START_Y:   prdata = PDW'(start_y);
      REG_TARGET_X:  prdata = PDW'(target_x);
      REG_TARGET_Y:  prdata = PDW'(target_y);
      REG_RADIUS:    prdata = PDW'(radius);
      REG_INTENSITY: prdata = PDW'(intensity);
      default:       prdata = '0;
    endcase
  end

  logic en;
  logic skid_valid;
  assign en             = !skid_valid;
  assign vertices.ready = en;

  // front end: offsets, squares, exact inside test
  logic         s0_valid, s1_valid, s2_valid, s3_valid;
  logic [W-1:0] s0_vx, s0_vy, s1_vx, s1_vy, s2_vx, s2_vy, s3_vx, s3_vy;
  logic signed [W:0] dx, dy;
  logic [W:0]   ax, ay;
  logic [MW-1:0] ax_ext, ay_ext;
  logic         s1_xlt, s1_ylt, s2_xlt, s2_ylt, s3_inside;
  logic [31:0]  s1_ax, s1_ay;
  logic [63:0]  s2_a2, s2_b2, s2_rr, s3_sq;
  logic [64:0]  sq_sum;

  always_comb begin
    dx     = $signed({s0_vx[W-1], s0_vx}) - $signed({start_x[W-1], start_x});
    dy     = $signed({s0_vy[W-1], s0_vy}) - $signed({start_y[W-1], start_y});
    ax     = dx[W] ? (~dx + 1'b1) : dx;
    ay     = dy[W] ? (~dy + 1'b1) : dy;
    ax_ext = MW'(ax);
    ay_ext = MW'(ay);
    sq_sum = {1'b0, s2_a2} + {1'b0, s2_b2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= vertices.valid;
      s0_vx    <= vertices.vertex_x;
      s0_vy    <= vertices.vertex_y;

      s1_valid <= s0_valid;
      s1_vx    <= s0_vx;
      s1_vy    <= s0_vy;
      s1_ax    <= ax_ext[31:0];
      s1_ay    <= ay_ext[31:0];
      s1_xlt   <= ax_ext < MW'(radius);
      s1_ylt   <= ay_ext < MW'(radius);

      s2_valid <= s1_valid;
      s2_vx    <= s1_vx;
      s2_vy    <= s1_vy;
      s2_xlt   <= s1_xlt;
      s2_ylt   <= s1_ylt;
      s2_a2    <= s1_ax * s1_ax;
      s2_b2    <= s1_ay * s1_ay;
      s2_rr    <= radius * radius;

      s3_valid  <= s2_valid;
      s3_vx     <= s2_vx;
      s3_vy     <= s2_vy;
      s3_sq     <= sq_sum[63:0];
      s3_inside <= (radius != '0) && s2_xlt && s2_ylt && !sq_sum[64] &&
                   (sq_sum[63:0] < s2_rr);
    end
  end

  // square root cell chain
  logic                sq_valid [0:SQRT_STEPS];
  logic [SQ_W-1:0]     sq_n     [0:SQRT_STEPS];
  logic [SQ_REM_W-1:0] sq_rem   [0:SQRT_STEPS];
  logic [ROOT_W-1:0]   sq_root  [0:SQRT_STEPS];
  logic [TAG_W-1:0]    sq_tag   [0:SQRT_STEPS];

  assign sq_valid[0] = s3_valid;
  assign sq_n[0]     = s3_sq;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_tag[0]   = {s3_inside, s3_vx, s3_vy};

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    rsw_sqrt_cell #(.TAG_W(TAG_W)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (sq_valid[k]),
      .in_n      (sq_n[k]),
      .in_rem    (sq_rem[k]),
      .in_root   (sq_root[k]),
      .in_tag    (sq_tag[k]),
      .out_valid (sq_valid[k+1]),
      .out_n     (sq_n[k+1]),
      .out_rem   (sq_rem[k+1]),
      .out_root  (sq_root[k+1]),
      .out_tag   (sq_tag[k+1])
    );
  end

  // divide cell chain: f = ((r - d) << 31) / r
  logic                dv_valid [0:DIV_STEPS];
  logic [RADIUS_W-1:0] dv_rem   [0:DIV_STEPS];
  logic [QUOT_W-1:0]   dv_num   [0:DIV_STEPS];
  logic [QUOT_W-1:0]   dv_q     [0:DIV_STEPS];
  logic [TAG_W-1:0]    dv_tag   [0:DIV_STEPS];
  logic [RADIUS_W-1:0] r_minus_d;

  assign r_minus_d   = radius - sq_root[SQRT_STEPS];
  assign dv_valid[0] = sq_valid[SQRT_STEPS];
  assign dv_rem[0]   = {1'b0, r_minus_d[RADIUS_W-1:1]};
  assign dv_num[0]   = {r_minus_d[0], {(QUOT_W-1){1'b0}}};
  assign dv_q[0]     = '0;
  assign dv_tag[0]   = sq_tag[SQRT_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    rsw_div_cell #(.TAG_W(TAG_W)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .divisor   (radius),
      .in_valid  (dv_valid[k]),
      .in_rem    (dv_rem[k]),
      .in_num    (dv_num[k]),
      .in_q      (dv_q[k]),
      .in_tag    (dv_tag[k]),
      .out_valid (dv_valid[k+1]),
      .out_rem   (dv_rem[k+1]),
      .out_num   (dv_num[k+1]),
      .out_q     (dv_q[k+1]),
      .out_tag   (dv_tag[k+1])
    );
  end

  // smoothstep weight
  logic               t0_valid, t1_valid, t2_valid;
  logic [TAG_W-1:0]   t0_tag, t1_tag, t2_tag;
  logic [31:0]        t0_f2, t1_s0;
  logic [32:0]        t0_t;
  logic [SMAG_W-1:0]  t2_smag;
  logic               t2_sneg;
  logic [63:0]        ff;
  logic [33:0]        t_full;
  logic [64:0]        f2t;
  logic [INTEN_W-1:0] imag;

  always_comb begin
    ff     = dv_q[DIV_STEPS] * dv_q[DIV_STEPS];
    t_full = SMOOTH_THREE - {1'b0, dv_q[DIV_STEPS], 1'b0};
    f2t    = t0_f2 * t0_t;
    imag   = intensity[INTEN_W-1] ? (~intensity + 1'b1) : intensity;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t0_valid <= 1'b0;
      t1_valid <= 1'b0;
      t2_valid <= 1'b0;
    end else if (en) begin
      t0_valid <= dv_valid[DIV_STEPS];
      t0_tag   <= dv_tag[DIV_STEPS];
      t0_f2    <= ff[62:FRAC_BITS];
      t0_t     <= t_full[32:0];

      t1_valid <= t0_valid;
      t1_tag   <= t0_tag;
      t1_s0    <= f2t[62:FRAC_BITS];

      t2_valid <= t1_valid;
      t2_tag   <= t1_tag;
      t2_smag  <= t1_s0 * imag;
      t2_sneg  <= intensity[INTEN_W-1];
    end
  end

  // per-axis displacement and saturation
  logic [W-1:0] lane_mx, lane_my;
  logic         ln_valid  [1:LANE_LAT];
  logic         ln_inside [1:LANE_LAT];

  rsw_move_lane #(.W(W)) u_lane_x (
    .clk    (clk),
    .en     (en),
    .start  (start_x),
    .target (target_x),
    .s_mag  (t2_smag),
    .s_neg  (t2_sneg),
    .v      (t2_tag[2*W-1:W]),
    .hit    (t2_tag[2*W]),
    .moved  (lane_mx)
  );

  rsw_move_lane #(.W(W)) u_lane_y (
    .clk    (clk),
    .en     (en),
    .start  (start_y),
    .target (target_y),
    .s_mag  (t2_smag),
    .s_neg  (t2_sneg),
    .v      (t2_tag[W-1:0]),
    .hit    (t2_tag[2*W]),
    .moved  (lane_my)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= LANE_LAT; i++) ln_valid[i] <= 1'b0;
    end else if (en) begin
      ln_valid[1]  <= t2_valid;
      ln_inside[1] <= t2_tag[2*W];
      for (int i = 2; i <= LANE_LAT; i++) begin
        ln_valid[i]  <= ln_valid[i-1];
        ln_inside[i] <= ln_inside[i-1];
      end
    end
  end

  // output register with one skid entry
  logic         out_valid, out_inside, skid_inside;
  logic [W-1:0] out_mx, out_my, skid_mx, skid_my;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || results.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_mx     <= skid_mx;
        out_my     <= skid_my;
        out_inside <= skid_inside;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= ln_valid[LANE_LAT];
        out_mx     <= lane_mx;
        out_my     <= lane_my;
        out_inside <= ln_inside[LANE_LAT];
      end
    end else if (ln_valid[LANE_LAT] && en) begin
      skid_valid  <= 1'b1;
      skid_mx     <= lane_mx;
      skid_my     <= lane_my;
      skid_inside <= ln_inside[LANE_LAT];
    end
  end

  assign results.valid         = out_valid;
  assign results.moved_x       = out_mx;
  assign results.moved_y       = out_my;
  assign results.inside_radius = out_inside;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import rsw_pkg::*;

  localparam int CW = 32;
  localparam int LATENCY = 77;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 2000;

  typedef struct packed {
    logic [CW-1:0] vx;
    logic [CW-1:0] vy;
  } vertex_t;

  typedef struct packed {
    logic [CW-1:0] mx;
    logic [CW-1:0] my;
    logic          in_zone;
  } warp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  rsw_vertex_if #(CW) vtx ();
  rsw_result_if #(CW) res ();

  radial_smoothstep_warp_unit #(.COORD_WIDTH(CW)) dut (
    .clk(clk), .rst(rst), .vertices(vtx.sink), .results(res.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow register values
  logic signed [CW-1:0] start_x, start_y, target_x, target_y;
  logic [31:0] radius;
  logic signed [23:0] intensity;

  vertex_t pending_vertices[$];
  warp_t expected_warps[$];
  int errors = 0;
  int n_checked = 0;
  int n_inside = 0;
  int idle_cycles = 0;

  function automatic logic [63:0] root_floor(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // vertex + delta*weight/2^47, floor, saturated
  function automatic logic [CW-1:0] shift_coord(logic signed [63:0] v,
      logic signed [63:0] delta, logic signed [63:0] weight);
    logic signed [159:0] prod;
    logic signed [159:0] sum;
    prod = (160'(delta) * 160'(weight)) >>> 47;
    sum = 160'(v) + prod;
    if (sum > 160'sd2147483647) return 32'h7fff_ffff;
    if (sum < -160'sd2147483648) return 32'h8000_0000;
    return sum[CW-1:0];
  endfunction

  function automatic warp_t warp_vertex(vertex_t v);
    warp_t w;
    logic signed [63:0] dxs, dys;
    logic [63:0] ax, ay, sq, d, f, f2, t, s0, r;
    logic signed [63:0] wgt;
    w.mx = v.vx;
    w.my = v.vy;
    w.in_zone = 1'b0;
    r = {32'b0, radius};
    dxs = 64'(signed'(v.vx)) - 64'(start_x);
    dys = 64'(signed'(v.vy)) - 64'(start_y);
    ax = dxs < 0 ? -dxs : dxs;
    ay = dys < 0 ? -dys : dys;
    if (r != 0 && ax < r && ay < r) begin
      sq = ax * ax + ay * ay;
      if (sq >= ax * ax && sq < r * r) w.in_zone = 1'b1;
    end
    if (w.in_zone) begin
      d = root_floor(sq);
      f = ((r - d) << 31) / r;
      f2 = (f * f) >> 31;
      t = (64'd3 << 31) - 2 * f;
      s0 = (f2 * t) >> 31;
      wgt = $signed(s0) * 64'(intensity);
      w.mx = shift_coord(64'(signed'(v.vx)), 64'(target_x) - 64'(start_x), wgt);
      w.my = shift_coord(64'(signed'(v.vy)), 64'(target_y) - 64'(start_y), wgt);
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic queue_vertex(vertex_t v);
    pending_vertices = {pending_vertices, v};
  endtask

  // vertex driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      vtx.valid <= 1'b0;
      vtx.vertex_x <= '0;
      vtx.vertex_y <= '0;
    end else if (!vtx.valid || vtx.ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        vtx.valid <= 1'b0;
      end else if (pending_vertices.size() > 0) begin
        vtx.valid <= 1'b1;
        vtx.vertex_x <= pending_vertices[0].vx;
        vtx.vertex_y <= pending_vertices[0].vy;
        expected_warps = {expected_warps, warp_vertex(pending_vertices[0])};
        void'(pending_vertices.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        vtx.valid <= 1'b0;
      end
    end
  end

  // result sink stall pattern
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 512 < 128) res.ready <= 1'b1;
      else res.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (res.valid && res.ready) begin
        if (expected_warps.size() == 0) begin
          report_mismatch("unexpected result", res.moved_x, '0);
        end else begin
          if (res.moved_x !== expected_warps[0].mx)
            report_mismatch("moved_x", res.moved_x, expected_warps[0].mx);
          if (res.moved_y !== expected_warps[0].my)
            report_mismatch("moved_y", res.moved_y, expected_warps[0].my);
          if (res.inside_radius !== expected_warps[0].in_zone)
            report_mismatch("inside_radius", 32'(res.inside_radius),
                            32'(expected_warps[0].in_zone));
          if (expected_warps[0].in_zone) n_inside++;
          void'(expected_warps.pop_front());
          n_checked++;
        end
      end
      if ((res.valid && res.ready) || (vtx.valid && vtx.ready) || psel
          || (expected_warps.size() == 0 && pending_vertices.size() == 0))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout waiting for results");
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_index_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_START_X:   start_x = value;
      REG_START_Y:   start_y = value;
      REG_TARGET_X:  target_x = value;
      REG_TARGET_Y:  target_y = value;
      REG_RADIUS:    radius = value;
      REG_INTENSITY: intensity = value[23:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pending_vertices.size() > 0 || expected_warps.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic configure(logic [31:0] sx, logic [31:0] sy, logic [31:0] tx,
      logic [31:0] ty, logic [31:0] r, logic [23:0] k);
    drain();
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_TARGET_X, tx);
    write_reg(REG_TARGET_Y, ty);
    write_reg(REG_RADIUS, r);
    write_reg(REG_INTENSITY, {{8{k[23]}}, k});
  endtask

  function automatic vertex_t near_vertex(int spread);
    vertex_t v;
    v.vx = start_x + $signed($urandom_range(0, 2 * spread)) - spread;
    v.vy = start_y + $signed($urandom_range(0, 2 * spread)) - spread;
    return v;
  endfunction

  function automatic vertex_t wild_vertex();
    vertex_t v;
    v.vx = $urandom;
    v.vy = $urandom;
    return v;
  endfunction

  task automatic random_phase(int count, int spread);
    repeat (count) begin
      if ($urandom_range(0, 4) == 0) queue_vertex(wild_vertex());
      else queue_vertex(near_vertex(spread));
    end
  endtask

  initial begin
    start_x = 0; start_y = 0; target_x = 0; target_y = 0;
    radius = 0; intensity = 24'(INTEN_RESET);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset values: zero radius, nothing moves
    queue_vertex('{32'h0, 32'h0});
    queue_vertex('{32'h7fff_ffff, 32'h8000_0000});

    // directed: center, edges, extremes, saturation
    configure(32'h0001_0000, 32'hffff_0000, 32'h7fff_ffff, 32'h8000_0000,
              32'h0010_0000, 24'h7fffff);
    queue_vertex('{32'h0001_0000, 32'hffff_0000});
    queue_vertex('{32'h0011_0000, 32'hffff_0000});
    queue_vertex('{32'h0010_ffff, 32'hffff_0000});
    queue_vertex('{32'h7fff_ffff, 32'h8000_0000});
    queue_vertex('{32'h0005_0000, 32'h0003_0000});
    configure(32'h0, 32'h0, 32'h0, 32'h0, 32'hffff_ffff, 24'h800000);
    queue_vertex('{32'h0, 32'h0});
    queue_vertex('{32'h8000_0000, 32'h8000_0000});
    queue_vertex('{32'h1234_0000, 32'hedcb_0000});
    configure(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
              32'hffff_ffff, 24'h800000);
    queue_vertex('{32'h8000_0000, 32'h7fff_ffff});
    queue_vertex('{32'h8000_1000, 32'h7fff_0000});
    configure(32'h0010_0000, 32'h0020_0000, 32'h0030_0000, 32'h0000_0000,
              32'h0008_0000, 24'h000000);
    queue_vertex('{32'h0010_0000, 32'h0020_0000});
    queue_vertex('{32'h0011_0000, 32'h0021_0000});

    // random phases over several settings
    for (int p = 0; p < 10; p++) begin
      logic [31:0] r;
      r = (p % 4 == 0) ? $urandom : $urandom_range(1, 32'h0100_0000);
      if (p == 9) r = 1;
      configure($urandom, $urandom, $urandom, $urandom, r, 24'($urandom));
      random_phase(N_RANDOM / 10, (r > 32'h7fff_ffff) ? 32'h7fff_ffff : r + r / 4 + 2);
    end
    drain();

    $display("checked %0d results, %0d inside the radius, over 15 settings",
             n_checked, n_inside);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
